FILE: rtl/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// Binary heap priority queue package
// Shared operation, status and state codes.
// ----------------------------------------------------------------------------
package bhpq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_REPLACE = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_REM_RD,
        S_REM_RDLAST,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_TOP_RD,
        S_TOP_WAIT,
        S_DONE
    } state_t;

endpackage

FILE: rtl/bhpq_ram.sv
// ----------------------------------------------------------------------------
// Binary heap priority queue RAM
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/binary_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// Binary heap priority queue
// Each input transaction carries one operation (insert, remove top, replace
// top or clear) and yields one result transaction with the new top, the
// count, the removed key and a status. The heap lives in one single-port RAM,
// so each operation is worked through in steps after it is accepted: an
// insert climbs the heap level by level, and a removal or replacement
// descends it level by level. A refusal or a clear goes straight to the
// result. One operation is worked on at a time, and the next one is
// accepted only after the result is loaded. The result register frees the
// input side as soon as the result is loaded, and a stalled result holds
// the block in its last step until it is taken.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue #(
    parameter int CAPACITY  = 256,
    parameter int KEY_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,        // order_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,         // op[1:0], key_value[33:2], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata          // top_key[31:0], top_valid[32],
                                         // entry_count[41:33], removed_key[73:42],
                                         // status[75:74], zero fill
);
    import bhpq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    state_t state_reg, state_next;
    logic                 mode_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [KEY_WIDTH-1:0] cur_reg, cur_next;
    logic [KEY_WIDTH-1:0] lkey_reg, lkey_next;
    logic [KEY_WIDTH-1:0] rem_reg, rem_next;
    logic [1:0]           st_reg, st_next;
    logic [KEY_WIDTH-1:0] top_reg, top_next;
    logic                 out_valid_reg, out_valid_next;
    logic [75:0]          res_reg, res_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [KEY_WIDTH-1:0] ram_wdata, ram_rdata;

    bhpq_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_ram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    function automatic logic goes_before(input logic m, input logic [KEY_WIDTH-1:0] a,
                                         input logic [KEY_WIDTH-1:0] b);
        return m ? (a < b) : (a > b);
    endfunction

    logic [1:0]           in_op;
    logic [KEY_WIDTH-1:0] in_key;
    logic [CW:0]          lidx, ridx;
    logic [AW-1:0]        parent;
    logic                 dn_lok, dn_rok;
    logic                 res_free;
    logic [31:0]          top_out, rem_out;

    assign in_op     = s_tdata[1:0];
    assign in_key    = KEY_WIDTH'(s_tdata[33:2]);
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign lidx      = (CW+1)'({pos_reg, 1'b1});
    assign ridx      = lidx + (CW+1)'(1);
    assign parent    = (pos_reg - AW'(1)) >> 1;
    assign dn_lok    = goes_before(mode_reg, lkey_reg, cur_reg);
    assign dn_rok    = (ridx < (CW+1)'(count_reg)) && goes_before(mode_reg, ram_rdata, cur_reg);
    assign res_free  = !out_valid_reg || m_tready;
    assign top_out   = (count_reg == '0) ? 32'd0 : 32'(top_reg);
    assign rem_out   = 32'(rem_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            mode_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
        end
        pos_reg  <= pos_next;
        cur_reg  <= cur_next;
        lkey_reg <= lkey_next;
        rem_reg  <= rem_next;
        st_reg   <= st_next;
        top_reg  <= top_next;
        res_reg  <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    case (in_op)
                        OP_INSERT:  state_next = (count_reg >= CW'(CAPACITY)) ? S_DONE
                                               : (count_reg == '0) ? S_TOP_RD : S_INS_RD;
                        OP_REMOVE:  state_next = (count_reg == '0) ? S_DONE : S_REM_RD;
                        OP_REPLACE: state_next = (count_reg == '0) ? S_DONE : S_REM_RD;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_INS_RD:     state_next = (pos_reg == '0) ? S_TOP_RD : S_INS_CMP;
            S_INS_CMP:    state_next = goes_before(mode_reg, cur_reg, ram_rdata)
                                     ? S_INS_RD : S_TOP_RD;
            S_REM_RD:     state_next = S_REM_RDLAST;
            S_REM_RDLAST: state_next = S_DN_RDL;
            S_DN_RDL:     state_next = (lidx < (CW+1)'(count_reg)) ? S_DN_RDR : S_TOP_RD;
            S_DN_RDR:     state_next = S_DN_CMP;
            S_DN_CMP:     state_next = (dn_lok || dn_rok) ? S_DN_RDL : S_TOP_RD;
            S_TOP_RD:     state_next = S_TOP_WAIT;
            S_TOP_WAIT:   state_next = S_DONE;
            S_DONE:       state_next = res_free ? S_IDLE : S_DONE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb begin
        count_next     = count_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        lkey_next      = lkey_reg;
        rem_next       = rem_reg;
        st_next        = st_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_addr       = pos_reg;
        ram_wdata      = cur_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    rem_next = '0;
                    st_next  = ST_OK;
                    cur_next = in_key;
                    case (in_op)
                        OP_INSERT: begin
                            if (count_reg >= CW'(CAPACITY)) begin
                                st_next = ST_FULL;
                            end else begin
                                pos_next   = AW'(count_reg);
                                count_next = count_reg + CW'(1);
                                ram_we     = (count_reg == '0);
                                ram_addr   = '0;
                                ram_wdata  = in_key;
                            end
                        end
                        OP_REMOVE, OP_REPLACE: begin
                            if (count_reg == '0) begin
                                st_next = ST_EMPTY;
                            end else begin
                                ram_addr = '0;
                                lkey_next = {KEY_WIDTH{in_op == OP_REMOVE}};
                            end
                        end
                        default: count_next = '0;
                    endcase
                end
            end
            S_INS_RD: begin
                if (pos_reg == '0) begin
                    ram_we = 1'b1;
                end else begin
                    ram_addr = parent;
                end
            end
            S_INS_CMP: begin
                ram_we = 1'b1;
                if (goes_before(mode_reg, cur_reg, ram_rdata)) begin
                    ram_wdata = ram_rdata;
                    pos_next  = parent;
                end
            end
            S_REM_RD: begin
                rem_next = ram_rdata;
                pos_next = '0;
                if (lkey_reg[0]) begin
                    count_next = count_reg - CW'(1);
                    ram_addr   = AW'(count_reg - CW'(1));
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                end
            end
            S_REM_RDLAST: begin
                if (lkey_reg[0]) begin
                    cur_next = ram_rdata;
                end
            end
            S_DN_RDL: begin
                ram_addr = AW'(lidx);
                if (!(lidx < (CW+1)'(count_reg))) begin
                    ram_we   = 1'b1;
                    ram_addr = pos_reg;
                end
            end
            S_DN_RDR: begin
                lkey_next = ram_rdata;
                ram_addr  = AW'(ridx);
            end
            S_DN_CMP: begin
                ram_we = 1'b1;
                if (dn_rok && (!dn_lok || goes_before(mode_reg, ram_rdata, lkey_reg))) begin
                    ram_wdata = ram_rdata;
                    pos_next  = AW'(ridx);
                end else if (dn_lok) begin
                    ram_wdata = lkey_reg;
                    pos_next  = AW'(lidx);
                end else begin
                    ram_wdata = cur_reg;
                    pos_next  = pos_reg;
                end
            end
            S_TOP_RD: begin
                ram_addr = '0;
            end
            S_TOP_WAIT: begin
                top_next = ram_rdata;
            end
            S_DONE: begin
                if (res_free) begin
                    out_valid_next = 1'b1;
                    res_next = {st_reg, rem_out, 9'(count_reg), (count_reg != '0), top_out};
                end
                if (count_reg == '0) begin
                    top_next = '0;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, res_reg};

endmodule
